>>> rtl/cps_pkg.sv
// shared types and constants for the cycle profile statistics block
`timescale 1ns / 1ps

package cps_pkg;

   // statistic and stamp width
   localparam int unsigned STAT_W = 32;

   // event kinds carried on the request tuser
   localparam int unsigned CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

   // reset value of the smallest interval
   localparam logic [STAT_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   // radix-2 divider, one quotient bit per cycle
   localparam int unsigned DIV_STEPS = STAT_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // result word: six statistics packed back to back
   localparam int unsigned RSP_W = 6 * STAT_W;

   // controller states
   typedef enum logic [1:0] {
      CPS_IDLE,
      CPS_DIVIDE,
      CPS_PUSH
   } cps_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;      // request transaction accepted this cycle
      logic div_step;  // advance the divider by one bit
      logic div_last;  // final divider step, write the mean
      logic load_out;  // copy the statistics into the result register
   } cps_cmd_type;

endpackage

>>> rtl/cps_ctrl.sv
// controller state machine: request handshake, divider sequencing, result handshake
`timescale 1ns / 1ps

module cps_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cps_pkg::CMD_W-1:0]        req_kind,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output cps_pkg::cps_cmd_type             cmd
);

   cps_pkg::cps_state_type           state_ff, state_in;
   logic [cps_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // state, step counter and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cps_pkg::CPS_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         cps_pkg::CPS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (req_kind == cps_pkg::CMD_END) begin
                  cnt_in   = '0;
                  state_in = cps_pkg::CPS_DIVIDE;
               end else begin
                  state_in = cps_pkg::CPS_PUSH;
               end
            end
         end
         cps_pkg::CPS_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == cps_pkg::DIV_CNT_W'(cps_pkg::DIV_STEPS - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = cps_pkg::CPS_PUSH;
            end
         end
         cps_pkg::CPS_PUSH: begin
            // wait for a free result register
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = cps_pkg::CPS_IDLE;
            end
         end
         default: begin
            state_in = cps_pkg::CPS_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared once the transaction is taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/cps_dpath.sv
// datapath: statistics registers, radix-2 mean divider and result register
`timescale 1ns / 1ps

module cps_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  cps_pkg::cps_cmd_type             cmd,
   input  logic [cps_pkg::CMD_W-1:0]        req_kind,
   input  logic [cps_pkg::STAT_W-1:0]       req_stamp,
   output logic [cps_pkg::RSP_W-1:0]        rsp_data
);

   localparam int unsigned W = cps_pkg::STAT_W;

   logic [W-1:0]     start_ff, start_in;
   logic [W-1:0]     end_ff, end_in;
   logic [W-1:0]     total_ff, total_in;
   logic [W-1:0]     count_ff, count_in;
   logic [W-1:0]     least_ff, least_in;
   logic [W-1:0]     greatest_ff, greatest_in;
   logic [W-1:0]     mean_ff, mean_in;
   logic [W-1:0]     elapsed;

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic [W:0]       rem_shift;
   logic [W:0]       rem_diff;

   logic [cps_pkg::RSP_W-1:0] out_ff, out_in;

   // interval of the incoming end stamp against the stored start
   assign elapsed = req_stamp - start_ff;

   // statistics update on an accepted transaction
   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      total_in    = total_ff;
      count_in    = count_ff;
      least_in    = least_ff;
      greatest_in = greatest_ff;
      mean_in     = mean_ff;
      if (cmd.take) begin
         case (req_kind)
            cps_pkg::CMD_CLEAR: begin
               start_in    = '0;
               end_in      = '0;
               total_in    = '0;
               count_in    = '0;
               least_in    = cps_pkg::ALL_ONES;
               greatest_in = '0;
               mean_in     = '0;
            end
            cps_pkg::CMD_START: begin
               start_in = req_stamp;
            end
            cps_pkg::CMD_END: begin
               end_in   = req_stamp;
               total_in = total_ff + elapsed;
               if (count_ff != cps_pkg::ALL_ONES) begin
                  count_in = count_ff + 1'b1;
               end
               if (elapsed < least_ff) begin
                  least_in = elapsed;
               end
               if (elapsed > greatest_ff) begin
                  greatest_in = elapsed;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.div_last) begin
         // final quotient bit joins the shifted quotient
         mean_in = {quo_ff[W-2:0], ~rem_diff[W]};
      end
   end

   // restoring divider step
   assign rem_shift = {rem_ff, quo_ff[W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (cmd.take) begin
         rem_in = '0;
         quo_in = total_in;
         den_in = count_in;
      end else if (cmd.div_step) begin
         if (!rem_diff[W]) begin
            rem_in = rem_diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   // result word, last_elapsed in the lowest bits
   always_comb begin
      out_in = out_ff;
      if (cmd.load_out) begin
         out_in = {mean_ff, greatest_ff, least_ff, count_ff, total_ff, end_ff - start_ff};
      end
   end

   // statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         end_ff      <= '0;
         total_ff    <= '0;
         count_ff    <= '0;
         least_ff    <= cps_pkg::ALL_ONES;
         greatest_ff <= '0;
         mean_ff     <= '0;
      end else begin
         start_ff    <= start_in;
         end_ff      <= end_in;
         total_ff    <= total_in;
         count_ff    <= count_in;
         least_ff    <= least_in;
         greatest_ff <= greatest_in;
         mean_ff     <= mean_in;
      end
   end

   // divider and result registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      out_ff <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

>>> rtl/cycle_profile_statistics.sv
// Cycle profile statistics unit: interval timing with total, count, min, max and mean.
//
// Request channel: req_tuser carries the event kind (clear, start mark, end mark),
// req_tdata the 32-bit cycle stamp. Clear resets every statistic; start latches
// the start stamp; end latches the end stamp and folds end minus start into the
// wrapping total, the saturating count, the minimum, the maximum and the mean.
// Every request transaction returns one response transaction carrying the
// statistics after the event, packed on rsp_tdata.
// Clear, start and unused kinds go from acceptance straight to the push state,
// which loads the result register and raises rsp_tvalid; an end mark first
// passes through the divide state, where the radix-2 divider forms the mean
// one quotient bit per cycle, and then to push. One event is processed at a
// time: a new request is taken only after the last one has been loaded.
// The result sits in an output register, so a new request is accepted while a
// finished response waits; a stalled receiver holds the response and the next
// event waits only if its own result is ready before the old one is taken.
// Synchronous reset returns all statistics to their cleared values (minimum all
// ones, everything else zero) and drops any response in flight.
`timescale 1ns / 1ps

module cycle_profile_statistics (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,  // [31:0] timestamp
   input  logic [1:0]    req_tuser,  // [1:0] cmd
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] last_elapsed, [63:32] total_cycles, [95:64] event_count,
   // [127:96] least_cycles, [159:128] greatest_cycles, [191:160] mean_cycles
   output logic [191:0]  rsp_tdata
);

   cps_pkg::cps_cmd_type cmd;

   // control: handshakes and divider sequencing
   cps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // statistics, divider and result register
   cps_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_kind  (req_tuser),
      .req_stamp (req_tdata),
      .rsp_data  (rsp_tdata)
   );

endmodule
